// ----- rtl/cstp_pkg.sv -----
// ----------------------------------------------------------------------------
// cstp_pkg: shared definitions for the call stack time profiler
// Stack sizing, result status codes and the command and status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cstp_pkg;

   // Stack sizing.
   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Field widths.
   localparam int WORD_W     = 64;
   localparam int DEPTH_W    = 6;
   localparam int OVF_W      = 16;
   localparam int IN_DATA_W  = 128;
   localparam int OUT_DATA_W = 264;

   localparam logic [OVF_W-1:0] OVF_MAX = '1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_PUSHED   = 3'd0,
      ST_EVENT    = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_OVF_PUSH = 3'd4,
      ST_OVF_EXIT = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               load_in;
      logic               rd_en;
      logic [PTR_W-1:0]   rd_addr;
      logic [PTR_W-1:0]   rd_parent_addr;
      logic               frame_wr;
      logic               child_wr;
      logic               child_sum;
      logic [PTR_W-1:0]   wr_addr;
      logic               load_calc;
      logic               load_rsp;
      status_type         rsp_status;
      logic [DEPTH_W-1:0] rsp_depth;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pc_match;
   } dp_status_type;

endpackage : cstp_pkg

`default_nettype wire

// ----- rtl/call_stack_time_profiler.sv -----
// ----------------------------------------------------------------------------
// call_stack_time_profiler: shadow call stack profiler
// Tracks function entries and exits on a shadow stack and reports the
// inclusive and exclusive time of every matched call that held a stack frame.
//
//   Group  Direction  Contents
//   req_   in         tuser: mode; tdata: call_addr, timestamp
//   rsp_   out        tuser: status; tdata: event_pc, event_start,
//                     event_duration, event_exclusive, event_depth
//
// A transfer is taken in the idle step, which for an exit that pops a frame also
// starts the registered read of the top frames. A push or a status-only outcome
// then loads the result; an exit that pops a frame first subtracts the duration
// and compares the address, then loads the result and updates parent child time.
// Reset clears the stack and overflow counts; frame memories need no clearing.
// A stalled result holds the sequencer in its final step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module call_stack_time_profiler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: call_addr [63:0], timestamp [127:64]
   input  logic [cstp_pkg::IN_DATA_W-1:0]  req_tdata,
   // tuser: mode [0]
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: event_pc [63:0], event_start [127:64], event_duration [191:128],
   //        event_exclusive [255:192], event_depth [261:256], zero fill
   output logic [cstp_pkg::OUT_DATA_W-1:0] rsp_tdata,
   // tuser: status [2:0]
   output logic [2:0]                      rsp_tuser
);
   import cstp_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_sts;

   // Sequencer and counts.
   cstp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .dp_sts     (dp_sts)
   );

   // Frame storage and arithmetic.
   cstp_datapath u_datapath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .dp_sts    (dp_sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule : call_stack_time_profiler

`default_nettype wire

// ----- rtl/cstp_ctrl.sv -----
// ----------------------------------------------------------------------------
// cstp_ctrl: controller of the call stack time profiler
// Keeps the stack and overflow counts, sequences each probe event through
// the datapath and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cstp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_mode,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output cstp_pkg::cmd_type       cmd,
   input  cstp_pkg::dp_status_type dp_sts
);
   import cstp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PUSH   = 5'b00010,
      S_SIMPLE = 5'b00100,
      S_CALC   = 5'b01000,
      S_FIN    = 5'b10000
   } ctrl_state_type;

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [OVF_W-1:0] ovf_ff, ovf_in;
   status_type       code_ff, code_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             emit;
   logic [CNT_W-1:0] top;

   // The result register can take a new result when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top        = count_ff - CNT_W'(1);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state, count updates and datapath commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      code_in  = code_ff;
      emit     = 1'b0;
      cmd                = '0;
      cmd.rd_addr        = PTR_W'(top);
      cmd.rd_parent_addr = PTR_W'(count_ff - CNT_W'(2));
      cmd.rsp_depth      = DEPTH_W'(top);
      cmd.rsp_status     = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               if (!req_mode) begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     state_in = S_SIMPLE;
                     code_in  = ST_OVF_PUSH;
                  end else begin
                     state_in = S_PUSH;
                  end
               end else if (ovf_ff != '0) begin
                  state_in = S_SIMPLE;
                  code_in  = ST_OVF_EXIT;
               end else if (count_ff == '0) begin
                  state_in = S_SIMPLE;
                  code_in  = ST_EMPTY;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_CALC;
               end
            end
         end
         S_PUSH: begin
            if (out_free) begin
               emit           = 1'b1;
               cmd.frame_wr   = 1'b1;
               cmd.child_wr   = 1'b1;
               cmd.wr_addr    = PTR_W'(count_ff);
               cmd.rsp_status = ST_PUSHED;
               count_in       = count_ff + CNT_W'(1);
               state_in       = S_IDLE;
            end
         end
         S_SIMPLE: begin
            if (out_free) begin
               emit = 1'b1;
               if (code_ff == ST_OVF_PUSH && ovf_ff != OVF_MAX) begin
                  ovf_in = ovf_ff + OVF_W'(1);
               end else if (code_ff == ST_OVF_EXIT) begin
                  ovf_in = ovf_ff - OVF_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_CALC: begin
            cmd.load_calc = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               emit           = 1'b1;
               cmd.rsp_status = dp_sts.pc_match ? ST_EVENT : ST_MISMATCH;
               count_in       = top;
               // A matched call hands its duration to the parent frame.
               if (dp_sts.pc_match && count_ff >= CNT_W'(2)) begin
                  cmd.child_wr  = 1'b1;
                  cmd.child_sum = 1'b1;
                  cmd.wr_addr   = PTR_W'(count_ff - CNT_W'(2));
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.load_rsp = emit;
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= '0;
         code_ff      <= ST_PUSHED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The stack count never passes the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above capacity");

   // Unstored frames exist only while the stack is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff != '0) |-> (count_ff == CNT_W'(STACK_DEPTH)))
      else $error("overflow count set while stack not full");

   // A result is loaded only when the result register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded over a pending result");

   // A completed push raises the stack count by one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && out_free) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not advance the stack count");

endmodule : cstp_ctrl

`default_nettype wire

// ----- rtl/cstp_datapath.sv -----
// ----------------------------------------------------------------------------
// cstp_datapath: frame memories and timing arithmetic
// Holds the frame memories, the captured probe event, the duration and
// exclusive time arithmetic and the result payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module cstp_datapath (
   input  logic                               clock,
   input  logic [cstp_pkg::IN_DATA_W-1:0]     req_tdata,
   input  cstp_pkg::cmd_type                  cmd,
   output cstp_pkg::dp_status_type            dp_sts,
   output logic [cstp_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic [2:0]                         rsp_tuser
);
   import cstp_pkg::*;

   // Frame memories: {start, pc} and child time.
   logic [2*WORD_W-1:0] mem_frame [STACK_DEPTH];
   logic [WORD_W-1:0]   mem_child [STACK_DEPTH];

   logic [WORD_W-1:0]  in_pc_ff, in_time_ff;
   logic [WORD_W-1:0]  rd_pc_ff, rd_start_ff, rd_child_ff, rd_parent_ff;
   logic [WORD_W-1:0]  dur_ff;
   logic               match_ff;
   status_type         out_status_ff;
   logic [WORD_W-1:0]  out_pc_ff, out_start_ff, out_dur_ff, out_excl_ff;
   logic [DEPTH_W-1:0] out_depth_ff;
   logic [WORD_W-1:0]  excl;
   logic [WORD_W-1:0]  child_wdata;
   logic               is_event;

   // Capture the accepted probe event.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_pc_ff   <= req_tdata[WORD_W-1:0];
         in_time_ff <= req_tdata[2*WORD_W-1:WORD_W];
      end
   end

   // Child time written on a push is zero, on a matched exit the parent sum.
   assign child_wdata = cmd.child_sum ? (rd_parent_ff + dur_ff) : '0;

   // Frame memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.frame_wr) begin
         mem_frame[cmd.wr_addr] <= {in_time_ff, in_pc_ff};
      end
      if (cmd.rd_en) begin
         {rd_start_ff, rd_pc_ff} <= mem_frame[cmd.rd_addr];
      end
   end

   // Child time memory: one write port, top and parent read ports.
   always_ff @(posedge clock) begin
      if (cmd.child_wr) begin
         mem_child[cmd.wr_addr] <= child_wdata;
      end
      if (cmd.rd_en) begin
         rd_child_ff  <= mem_child[cmd.rd_addr];
         rd_parent_ff <= mem_child[cmd.rd_parent_addr];
      end
   end

   // Inclusive duration and address match.
   always_ff @(posedge clock) begin
      if (cmd.load_calc) begin
         dur_ff   <= in_time_ff - rd_start_ff;
         match_ff <= (rd_pc_ff == in_pc_ff);
      end
   end

   assign dp_sts.pc_match = match_ff;

   // Exclusive time floors at zero.
   assign excl     = (dur_ff > rd_child_ff) ? (dur_ff - rd_child_ff) : '0;
   assign is_event = (cmd.rsp_status == ST_EVENT);

   // Result payload register; fields other than status are zero off events.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_status_ff <= cmd.rsp_status;
         out_pc_ff     <= is_event ? in_pc_ff     : '0;
         out_start_ff  <= is_event ? rd_start_ff  : '0;
         out_dur_ff    <= is_event ? dur_ff       : '0;
         out_excl_ff   <= is_event ? excl         : '0;
         out_depth_ff  <= is_event ? cmd.rsp_depth : '0;
      end
   end

   assign rsp_tuser = out_status_ff;
   assign rsp_tdata = {2'b00, out_depth_ff, out_excl_ff, out_dur_ff, out_start_ff,
                       out_pc_ff};

endmodule : cstp_datapath

`default_nettype wire
